@@ src/mclp_pkg.sv @@
// Shared types, codes and character constants of the motion command line parser.
package mclp_pkg;

  typedef enum logic [2:0] {
    KIND_INVALID = 3'd0,
    KIND_STOP    = 3'd1,
    KIND_PING    = 3'd2,
    KIND_MOVE    = 3'd3,
    KIND_DIFF    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    DIR_F       = 3'd0,
    DIR_B       = 3'd1,
    DIR_L       = 3'd2,
    DIR_R       = 3'd3,
    DIR_UNKNOWN = 3'd4
  } dir_e;

  localparam logic [1:0] KW_STOP = 2'd0;
  localparam logic [1:0] KW_PING = 2'd1;
  localparam logic [1:0] KW_DIFF = 2'd2;
  localparam logic [1:0] KW_MOVE = 2'd3;

  localparam logic [31:0] TXT_STOP = "STOP";
  localparam logic [31:0] TXT_PING = "PING";
  localparam logic [31:0] TXT_DIFF = "DIFF";
  localparam logic [31:0] TXT_MOVE = "MOVE";

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_LOW_A = "a";
  localparam logic [7:0] CH_LOW_Z = "z";
  localparam logic [7:0] CH_F     = "F";
  localparam logic [7:0] CH_B     = "B";
  localparam logic [7:0] CH_L     = "L";
  localparam logic [7:0] CH_R     = "R";
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] ch;
    logic       present;
    logic       last;
    logic       ws;
    logic       space;
    logic       digit;
  } entry_t;

  typedef struct packed {
    kind_e      kind;
    logic [1:0] direction;
    logic [7:0] speed;
    logic [7:0] left_speed;
    logic [7:0] right_speed;
  } res_t;

  function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [1:0] pos);
    logic [31:0] w;
    logic [31:0] s;
    unique case (kw)
      KW_STOP: w = TXT_STOP;
      KW_PING: w = TXT_PING;
      KW_DIFF: w = TXT_DIFF;
      default: w = TXT_MOVE;
    endcase
    s = w >> {~pos, 3'b000};
    return s[7:0];
  endfunction

endpackage

@@ src/mclp_if.sv @@
// Request channels of the parser: incoming line bytes and decoded commands.
interface mclp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       ch_present;
  logic       line_last;

  modport source (output valid, output ch, output ch_present, output line_last, input ready);
  modport sink (input valid, input ch, input ch_present, input line_last, output ready);
endinterface

interface mclp_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [1:0] direction;
  logic [7:0] speed;
  logic [7:0] left_speed;
  logic [7:0] right_speed;

  modport source (output valid, output kind, output direction, output speed,
                  output left_speed, output right_speed, input ready);
  modport sink (input valid, input kind, input direction, input speed,
                input left_speed, input right_speed, output ready);
endinterface

@@ src/mclp_front.sv @@
// Front end: accept line bytes, classify and case-fold them, drop empty items.
module mclp_front (
  mclp_byte_if.sink        byte_i,
  input  logic             q_ready_i,
  output logic             push_o,
  output mclp_pkg::entry_t entry_o
);
  import mclp_pkg::*;

  logic [7:0] ch;

  assign ch = byte_i.ch;
  assign byte_i.ready = q_ready_i;
  assign push_o = byte_i.valid && q_ready_i && (byte_i.ch_present || byte_i.line_last);

  always_comb begin
    entry_o.ch      = (ch >= CH_LOW_A && ch <= CH_LOW_Z) ? ch - CASE_OFS : ch;
    entry_o.present = byte_i.ch_present;
    entry_o.last    = byte_i.line_last;
    entry_o.space   = (ch == CH_SPACE);
    entry_o.ws      = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    entry_o.digit   = (ch >= CH_ZERO && ch <= CH_NINE);
  end
endmodule

@@ src/mclp_fifo.sv @@
// Short request queue between the classifying front end and the parsing back end.
module mclp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mclp_pkg::entry_t entry_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output mclp_pkg::entry_t entry_o
);
  import mclp_pkg::*;

  entry_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count exceeds depth");

  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not advance on push");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");
endmodule

@@ src/mclp_back.sv @@
// Back end: run the token parser on queued bytes and register the decoded command.
module mclp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  mclp_pkg::entry_t entry_i,
  output logic             pop_o,
  mclp_cmd_if.source       cmd_o
);
  import mclp_pkg::*;

  typedef struct packed {
    logic       started;
    logic       in_token;
    logic [2:0] tok_num;
    logic [3:0] kw_match;
    logic [2:0] char_cnt;
    logic [7:0] acc;
    logic       nf_digits;
    logic       nf_done;
    logic       nf_minus;
    logic       nf_over;
    logic [7:0] first_val;
    dir_e       dir_code;
    logic       bad;
  } pst_t;

  function automatic pst_t pst_clear();
    pst_t r;
    r = '0;
    r.kw_match = 4'hF;
    r.dir_code = DIR_UNKNOWN;
    return r;
  endfunction

  function automatic logic num_ok(input pst_t p);
    return !p.nf_over && !(p.nf_minus && p.acc != 8'd0);
  endfunction

  function automatic pst_t num_feed(input pst_t p, input entry_t e);
    pst_t        r;
    logic        acc_en;
    logic [11:0] v;
    r = p;
    acc_en = 1'b0;
    v = {4'b0, p.acc} * 12'd10 + {8'b0, e.ch[3:0]};
    if (!p.nf_done) begin
      if (!p.nf_digits) begin
        if (!e.ws) begin
          if (e.ch == CH_PLUS || e.ch == CH_MINUS) begin
            r.nf_digits = 1'b1;
            r.nf_minus  = (e.ch == CH_MINUS);
          end else if (!e.digit) begin
            r.nf_done = 1'b1;
          end else begin
            r.nf_digits = 1'b1;
            acc_en = 1'b1;
          end
        end
      end else if (!e.digit) begin
        r.nf_done = 1'b1;
      end else begin
        acc_en = 1'b1;
      end
    end
    if (acc_en && !p.nf_over) begin
      if (v > 12'd255) begin
        r.nf_over = 1'b1;
      end else begin
        r.acc = v[7:0];
      end
    end
    return r;
  endfunction

  function automatic pst_t token_start(input pst_t p);
    pst_t r;
    r = p;
    if (p.tok_num != 3'd7) begin
      r.tok_num = p.tok_num + 3'd1;
    end
    if (r.tok_num > 3'd3) begin
      r.bad = 1'b1;
    end
    r.in_token  = 1'b1;
    r.char_cnt  = '0;
    r.acc       = '0;
    r.nf_digits = 1'b0;
    r.nf_done   = 1'b0;
    r.nf_minus  = 1'b0;
    r.nf_over   = 1'b0;
    return r;
  endfunction

  function automatic pst_t token_end(input pst_t p);
    pst_t r;
    logic mv;
    logic df;
    r = p;
    mv = p.kw_match[KW_MOVE];
    df = p.kw_match[KW_DIFF];
    if (p.tok_num == 3'd1) begin
      if (p.char_cnt != 3'd4) begin
        r.kw_match = '0;
      end
      if (r.kw_match == '0) begin
        r.bad = 1'b1;
      end
    end else if (p.tok_num == 3'd2 && mv) begin
      if (p.char_cnt != 3'd1 || p.dir_code == DIR_UNKNOWN) begin
        r.bad = 1'b1;
      end
    end else if (p.tok_num == 3'd2 && df) begin
      if (p.char_cnt < 3'd2 || !num_ok(p)) begin
        r.bad = 1'b1;
      end
      r.first_val = p.acc;
    end else if (p.tok_num == 3'd3 && df) begin
      if (p.char_cnt < 3'd2 || !num_ok(p)) begin
        r.bad = 1'b1;
      end
    end else if (p.tok_num == 3'd3 && mv) begin
      if (!num_ok(p)) begin
        r.bad = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic pst_t token_char(input pst_t p, input entry_t e);
    pst_t r;
    logic mv;
    logic df;
    r = p;
    mv = p.kw_match[KW_MOVE];
    df = p.kw_match[KW_DIFF];
    if (p.tok_num == 3'd1) begin
      for (int i = 0; i < 4; i++) begin
        if (p.char_cnt[2] || e.ch != kw_char(2'(i), p.char_cnt[1:0])) begin
          r.kw_match[i] = 1'b0;
        end
      end
    end else if (p.tok_num == 3'd2 && mv) begin
      if (p.char_cnt == 3'd0) begin
        unique case (e.ch)
          CH_F:    r.dir_code = DIR_F;
          CH_B:    r.dir_code = DIR_B;
          CH_L:    r.dir_code = DIR_L;
          CH_R:    r.dir_code = DIR_R;
          default: r.dir_code = DIR_UNKNOWN;
        endcase
      end
    end else if ((p.tok_num == 3'd2 || p.tok_num == 3'd3) && df) begin
      if (p.char_cnt == 3'd0) begin
        if (e.ch != ((p.tok_num == 3'd2) ? CH_L : CH_R)) begin
          r.bad = 1'b1;
        end
      end else begin
        r = num_feed(r, e);
      end
    end else if (p.tok_num == 3'd3 && mv) begin
      r = num_feed(r, e);
    end
    if (p.char_cnt != 3'd7) begin
      r.char_cnt = p.char_cnt + 3'd1;
    end
    return r;
  endfunction

  function automatic pst_t feed(input pst_t p, input entry_t e);
    pst_t r;
    r = p;
    if (e.space) begin
      if (p.in_token) begin
        r = token_end(p);
        r.in_token = 1'b0;
      end
    end else begin
      if (!p.in_token) begin
        r = token_start(p);
      end
      r = token_char(r, e);
    end
    return r;
  endfunction

  pst_t live_q, live_d, live_n;
  pst_t held_q, held_d, held_n;
  pst_t fin;
  res_t res_q, res_d, res_n;
  logic out_valid_q, out_valid_d;
  logic pop_last;

  assign pop_o    = q_valid_i && (!out_valid_q || cmd_o.ready);
  assign pop_last = pop_o && entry_i.last;

  always_comb begin
    live_n = live_q;
    held_n = held_q;
    if (entry_i.present && (live_q.started || !entry_i.ws)) begin
      live_n = feed(live_q, entry_i);
      live_n.started = 1'b1;
      if (!entry_i.ws) begin
        held_n = live_n;
      end
    end

    fin = token_end(held_n);
    res_n = '{kind: KIND_INVALID, direction: 2'd0, speed: 8'd0,
              left_speed: 8'd0, right_speed: 8'd0};
    if (held_n.started && held_n.in_token && !fin.bad) begin
      if (fin.tok_num == 3'd1 && fin.kw_match[KW_STOP]) begin
        res_n.kind = KIND_STOP;
      end else if (fin.tok_num == 3'd1 && fin.kw_match[KW_PING]) begin
        res_n.kind = KIND_PING;
      end else if (fin.tok_num == 3'd3 && fin.kw_match[KW_MOVE]) begin
        res_n.kind      = KIND_MOVE;
        res_n.direction = fin.dir_code[1:0];
        res_n.speed     = fin.acc;
      end else if (fin.tok_num == 3'd3 && fin.kw_match[KW_DIFF]) begin
        res_n.kind        = KIND_DIFF;
        res_n.left_speed  = fin.first_val;
        res_n.right_speed = fin.acc;
      end
    end

    live_d = live_q;
    held_d = held_q;
    res_d  = res_q;
    out_valid_d = out_valid_q && !cmd_o.ready;
    if (pop_o) begin
      if (entry_i.last) begin
        live_d = pst_clear();
        held_d = pst_clear();
        res_d  = res_n;
        out_valid_d = 1'b1;
      end else begin
        live_d = live_n;
        held_d = held_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= pst_clear();
      held_q      <= pst_clear();
      out_valid_q <= 1'b0;
    end else begin
      live_q      <= live_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign cmd_o.valid       = out_valid_q;
  assign cmd_o.kind        = res_q.kind;
  assign cmd_o.direction   = res_q.direction;
  assign cmd_o.speed       = res_q.speed;
  assign cmd_o.left_speed  = res_q.left_speed;
  assign cmd_o.right_speed = res_q.right_speed;

  a_result_from_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pop_last))
    else $error("command raised without a line end");

  a_clear_after_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_last |=> !live_q.started && !held_q.started)
    else $error("parser state not cleared after line end");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == KIND_INVALID |->
      res_q.direction == 2'd0 && res_q.speed == 8'd0 &&
      res_q.left_speed == 8'd0 && res_q.right_speed == 8'd0)
    else $error("invalid command carries nonzero fields");
endmodule

@@ src/motion_command_line_parser_top.sv @@
// A command becomes valid when the back end pops the queued request that ends its line and registers the result.
// Throughput: one byte request per cycle; a waiting command does not stall input
// until the two-entry queue fills.
// Per-byte work is one token-state update with a times-ten accumulate in the back end.
// Reset (rst_ni low, asynchronous): queue empty, parser at start of line, no command.
// Top level of the motion command line parser.
module motion_command_line_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  mclp_byte_if.sink   byte_i,
  mclp_cmd_if.source  cmd_o
);
  import mclp_pkg::*;

  logic   push;
  logic   q_ready;
  logic   q_valid;
  logic   pop;
  entry_t entry_in;
  entry_t entry_out;

  mclp_front u_front (
    .byte_i    (byte_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .entry_o   (entry_in)
  );

  mclp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry_in),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (entry_out)
  );

  mclp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .entry_i   (entry_out),
    .pop_o     (pop),
    .cmd_o     (cmd_o)
  );
endmodule
